@@ design/mcc_pkg.sv @@
// Shared types and constants for the minimum coin change block.
package mcc_pkg;

  localparam int REG_COUNT  = 8;   // coin registers in the config space
  localparam int VAL_W      = 10;  // amount, coin and count width
  localparam int ENT_W      = 11;  // table entry: unreachable mark + count
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int TDATA_W    = 16;

  localparam logic [ENT_W-1:0] ENT_UNREACH = 11'h400;

  typedef logic [REG_COUNT-1:0][VAL_W-1:0] coin_arr_t;

  typedef struct packed {
    logic [VAL_W-1:0] min_coins;
    logic             unreachable;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

@@ design/mcc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module mcc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/mcc_cfg.sv @@
// Coin denomination register file.
module mcc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mcc_pkg::coin_arr_t               coins
);

  mcc_pkg::coin_arr_t coin_r;
  mcc_pkg::coin_arr_t coin_nxt;

  assign cfg_ready = 1'b1;
  assign coins     = coin_r;

  always_comb begin
    coin_nxt = coin_r;
    // indexes past the last register are dropped
    if (cfg_valid && (32'(cfg_index) < mcc_pkg::REG_COUNT)) begin
      coin_nxt[cfg_index[2:0]] = cfg_data[mcc_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coin_r <= '0;
    end else begin
      coin_r <= coin_nxt;
    end
  end

endmodule

@@ design/mcc_engine.sv @@
// Table-fill sequencer: one coin read per cycle, one table write per sum.
module mcc_engine #(
  parameter int TABLE_DEPTH = 1024,
  parameter int NUM_COINS   = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mcc_pkg::VAL_W-1:0]   in_amount,
  input  mcc_pkg::coin_arr_t          coins,
  output logic                        res_valid,
  input  logic                        res_ready,
  output mcc_pkg::res_t               res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KW = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(NUM_COINS - 1);

  mcc_pkg::state_t state_r, state_nxt;
  logic [mcc_pkg::VAL_W-1:0] amount_r, amount_nxt;
  logic [mcc_pkg::VAL_W-1:0] sum_r, sum_nxt;
  logic [KW-1:0]             k_r, k_nxt;
  logic [mcc_pkg::ENT_W-1:0] best_r, best_nxt;
  logic                      found_r, found_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  mcc_pkg::res_t             res_r, res_nxt;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [mcc_pkg::ENT_W-1:0] ram_wdata, ram_rdata;

  logic [mcc_pkg::VAL_W-1:0] coin;
  logic                      coin_use;
  logic [mcc_pkg::ENT_W-1:0] cand, best_upd;
  logic                      take, found_upd;

  mcc_ram #(
    .WIDTH (mcc_pkg::ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign coin      = coins[3'(k_r)];
  assign coin_use  = (coin != '0) && (coin <= sum_r);
  assign ram_raddr = AW'(sum_r - coin);
  assign ram_re    = (state_r == mcc_pkg::ST_SCAN) && coin_use;

  // fold in the entry read last cycle
  assign cand      = {1'b0, ram_rdata[mcc_pkg::VAL_W-1:0]} + 11'd1;
  assign take      = rd_vld_r && !ram_rdata[mcc_pkg::ENT_W-1] &&
                     (!found_r || (cand < best_r));
  assign best_upd  = take ? cand : best_r;
  assign found_upd = found_r || take;

  assign in_ready  = (state_r == mcc_pkg::ST_IDLE);
  assign res_valid = (state_r == mcc_pkg::ST_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt  = state_r;
    amount_nxt = amount_r;
    sum_nxt    = sum_r;
    k_nxt      = k_r;
    best_nxt   = best_r;
    found_nxt  = found_r;
    res_nxt    = res_r;
    rd_vld_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(sum_r);
    ram_wdata  = '0;
    case (state_r)
      mcc_pkg::ST_IDLE: begin
        if (in_valid) begin
          amount_nxt = in_amount;
          sum_nxt    = 10'd1;
          k_nxt      = '0;
          best_nxt   = '0;
          found_nxt  = 1'b0;
          if (32'(in_amount) >= TABLE_DEPTH) begin
            res_nxt   = '{min_coins: '0, unreachable: 1'b1};
            state_nxt = mcc_pkg::ST_DONE;
          end else begin
            // entry 0 is zero coins
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '0;
            if (in_amount == '0) begin
              res_nxt   = '{min_coins: '0, unreachable: 1'b0};
              state_nxt = mcc_pkg::ST_DONE;
            end else begin
              state_nxt = mcc_pkg::ST_SCAN;
            end
          end
        end
      end
      mcc_pkg::ST_SCAN: begin
        rd_vld_nxt = coin_use;
        best_nxt   = best_upd;
        found_nxt  = found_upd;
        k_nxt      = k_r + 1'b1;
        if (k_r == K_LAST) begin
          state_nxt = mcc_pkg::ST_WRITE;
        end
      end
      mcc_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = found_upd ? {1'b0, best_upd[mcc_pkg::VAL_W-1:0]}
                              : mcc_pkg::ENT_UNREACH;
        k_nxt     = '0;
        best_nxt  = '0;
        found_nxt = 1'b0;
        if (sum_r == amount_r) begin
          res_nxt   = found_upd ? '{min_coins: best_upd[mcc_pkg::VAL_W-1:0],
                                    unreachable: 1'b0}
                                : '{min_coins: '0, unreachable: 1'b1};
          state_nxt = mcc_pkg::ST_DONE;
        end else begin
          sum_nxt   = sum_r + 1'b1;
          state_nxt = mcc_pkg::ST_SCAN;
        end
      end
      mcc_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = mcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mcc_pkg::ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amount_r <= amount_nxt;
    sum_r    <= sum_nxt;
    k_r      <= k_nxt;
    best_r   <= best_nxt;
    found_r  <= found_nxt;
    res_r    <= res_nxt;
  end

endmodule

@@ design/min_coin_change_top.sv @@
// Top level of the minimum coin change block.
// Channels:
//   cfg_*  : register writes, index 0..7 selects coin_0..coin_7 (zero = unused
//            slot); other indexes are dropped. Always ready. Write only while
//            the block is idle.
//   in_*   : one request carries the target amount in in_tdata[9:0].
//   out_*  : one result per request: min_coins in out_tdata[9:0], the
//            unreachable flag in out_tuser[0].
// Sequence: a request fills the table from sum 1 up to the amount.
//   Each sum scans every coin slot with table reads (one coin per cycle on
//   the single read port of the table RAM) and then writes its entry back.
//   Amount zero, or an amount past the table, goes straight to the result with no table fill.
// Throughput: one request at a time; the next is taken as soon as the
//   sequencer is back in idle, even while the last result still waits in
//   the output register.
// Reset: rst_n (synchronous, active low) clears coins to zero, the sequencer
//   to idle and the output register to empty. The table RAM is not cleared;
//   every request rewrites entries 0..amount before reading them.
// Stall: a held-off out_tready keeps the result in the output register; a
//   second finished result waits in the sequencer and blocks new requests.
module min_coin_change_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int NUM_COINS   = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcc_pkg::CFG_DATA_W-1:0] cfg_data,   // [9:0] coin value
  // request channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mcc_pkg::TDATA_W-1:0]    in_tdata,   // [9:0] amount
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mcc_pkg::TDATA_W-1:0]    out_tdata,  // [9:0] min_coins
  output logic [0:0]                     out_tuser   // [0] unreachable
);

  mcc_pkg::coin_arr_t coins;
  mcc_pkg::res_t      res;
  logic               res_valid, res_ready;

  logic               out_valid_r, out_valid_nxt;
  mcc_pkg::res_t      out_res_r, out_res_nxt;

  mcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coins     (coins)
  );

  mcc_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_COINS   (NUM_COINS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_amount (in_tdata[mcc_pkg::VAL_W-1:0]),
    .coins     (coins),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mcc_pkg::TDATA_W - mcc_pkg::VAL_W){1'b0}}, out_res_r.min_coins};
  assign out_tuser  = out_res_r.unreachable;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the minimum coin change block.
`timescale 1ns / 100ps

module tb_top;

  localparam int VAL_W      = mcc_pkg::VAL_W;
  localparam int ENT_W      = mcc_pkg::ENT_W;
  localparam int REG_COUNT  = mcc_pkg::REG_COUNT;
  localparam int CFG_IDX_W  = mcc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = mcc_pkg::CFG_DATA_W;
  localparam int TDATA_W    = mcc_pkg::TDATA_W;

  typedef mcc_pkg::res_t res_t;

  // Hang guard. The slowest run this stimulus allows comes from a few dozen
  // large amounts, plus the small ones and stalls. The limit takes that
  // several times over.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_ITEMS = 70;
  localparam int NUM_PHASES  = 8;
  localparam int DEPTH       = 1024;
  localparam int TAIL_CYCLES = 40;

  // Register map of the config channel; indexes past coin_7 are spare and
  // the block drops writes to them.
  typedef enum logic [3:0] {
    REG_COIN_0   = 4'd0,
    REG_COIN_1   = 4'd1,
    REG_COIN_2   = 4'd2,
    REG_COIN_3   = 4'd3,
    REG_COIN_4   = 4'd4,
    REG_COIN_5   = 4'd5,
    REG_COIN_6   = 4'd6,
    REG_COIN_7   = 4'd7,
    REG_SPARE_8  = 4'd8,
    REG_SPARE_15 = 4'd15
  } reg_idx_t;

  typedef enum logic {ROW_CFG, ROW_QUERY} row_kind_t;

  // One row of the directed plan. Typed rows carry their answer; the others
  // are checked against the coin-count predictor.
  typedef struct {
    row_kind_t        kind;
    logic [3:0]       idx;
    logic [15:0]      data;
    logic [VAL_W-1:0] amount;
    bit               typed;
    logic [VAL_W-1:0] want_min;
    bit               want_unreach;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  min_coin_change_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Predictor state: our copy of the coin registers and of the count table.
  logic [VAL_W-1:0] coin_val [REG_COUNT];
  logic [ENT_W-1:0] fewest_tbl [DEPTH];

  res_t      answer_q [$];   // answers owed by the block, oldest first
  plan_row_t plan [$];
  res_t      want_res;
  int        err_count = 0;
  int        cycles = 0;
  int        send_gap_pct;   // chance per cycle that the sender holds off
  int        recv_stall_pct; // chance per cycle that the receiver stalls

  // -------------------------------------------------------------------------
  // Clock, cycle counter, hang guard
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[min_coin_change_top] ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Predictor: fill the fewest-coin table from 0 up to the amount, every
  // coin usable any number of times. Bit 10 of an entry marks "no way".
  // -------------------------------------------------------------------------
  function automatic res_t count_coins(input logic [VAL_W-1:0] amt);
    res_t             r;
    int               sum;
    int               k;
    int               c;
    int               best;
    bit               found;
    logic [ENT_W-1:0] prev;
    fewest_tbl[0] = '0;
    for (sum = 1; sum <= amt; sum++) begin
      found = 1'b0;
      best  = 0;
      for (k = 0; k < REG_COUNT; k++) begin
        c = coin_val[k];
        // unused slot, or a coin too big for this sum
        if (c != 0 && c <= sum) begin
          prev = fewest_tbl[sum - c];
          if (!prev[VAL_W] && (!found || int'(prev[VAL_W-1:0]) + 1 < best)) begin
            best  = int'(prev[VAL_W-1:0]) + 1;
            found = 1'b1;
          end
        end
      end
      fewest_tbl[sum] = found ? {1'b0, best[VAL_W-1:0]} : mcc_pkg::ENT_UNREACH;
    end
    if (fewest_tbl[amt][VAL_W]) begin
      r.min_coins   = '0;
      r.unreachable = 1'b1;
    end else begin
      r.min_coins   = fewest_tbl[amt][VAL_W-1:0];
      r.unreachable = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // -------------------------------------------------------------------------
  // Drivers. All of them are entered and left at a falling edge, and drive
  // with blocking assignments there; the block samples at the rising edge.
  // -------------------------------------------------------------------------

  // Register write: the copy in the predictor follows only real coin slots,
  // and keeps the low ten bits as the block does.
  task automatic cfg_write(input logic [3:0] idx, input logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < REG_COUNT)
      coin_val[idx[2:0]] = data[VAL_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = 16'($urandom);
  endtask

  // One amount request. The answer is worked out when the request is
  // accepted; a typed answer, when given, takes the predictor's place.
  task automatic send_amount(input logic [VAL_W-1:0] amt, input bit typed,
                             input res_t typed_res);
    res_t calc;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = 16'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(TDATA_W-VAL_W){1'b0}}, amt};
    do @(posedge clk); while (!in_tready);
    calc = count_coins(amt);
    answer_q = {answer_q, (typed ? typed_res : calc)};
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Registers change only while the block is idle: every answer is back,
  // then a short pause for the sequencer to settle.
  task automatic settle_block();
    while (answer_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 45; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 45; end
      default: begin send_gap_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  function automatic logic [VAL_W-1:0] pick_amount();
    int r;
    r = $urandom_range(99);
    // mostly short table fills, a few long ones up to the table end
    if (r < 85)
      return VAL_W'($urandom_range(0, 48));
    else if (r < 95)
      return VAL_W'($urandom_range(49, 300));
    return VAL_W'($urandom_range(301, 1023));
  endfunction

  // New coin set for one random phase. Phase 0 puts the largest coin in
  // every slot, phase 1 the smallest; the rest draw a mix with some slots
  // left empty. Every phase puts junk above bit 9 now and then.
  task automatic load_coins(input int phase);
    int          i;
    int          r;
    logic [15:0] data;
    for (i = 0; i < REG_COUNT; i++) begin
      r = $urandom_range(99);
      if (phase == 0)
        data = 16'd1023;
      else if (phase == 1)
        data = 16'd1;
      else if (r < 25)
        data = '0;
      else if (r < 80)
        data = 16'($urandom_range(1, 24));
      else if (r < 95)
        data = 16'($urandom_range(25, 200));
      else
        data = 16'($urandom_range(201, 1023));
      if ($urandom_range(3) == 0)
        data[15:VAL_W] = 6'($urandom);
      cfg_write(4'(REG_COIN_0 + i), data);
    end
    // spare index: must leave every coin as it is
    cfg_write(4'(REG_SPARE_8 + $urandom_range(0, 7)), 16'($urandom));
  endtask

  // -------------------------------------------------------------------------
  // Receiver: stalls at random per the current idling mode.
  // -------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Checker: each accepted result against the oldest owed answer.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (answer_q.size() == 0) begin
        report_mismatch("result with none owed", int'(out_tdata), -1);
      end else begin
        want_res = answer_q.pop_front();
        if (out_tdata[VAL_W-1:0] !== want_res.min_coins)
          report_mismatch("min_coins", int'(out_tdata[VAL_W-1:0]),
                          int'(want_res.min_coins));
        if (out_tuser[0] !== want_res.unreachable)
          report_mismatch("unreachable", int'(out_tuser[0]),
                          int'(want_res.unreachable));
        if (out_tdata[TDATA_W-1:VAL_W] !== '0)
          report_mismatch("tdata padding", int'(out_tdata[TDATA_W-1:VAL_W]), 0);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Directed plan
  // -------------------------------------------------------------------------
  function automatic void plan_cfg(input logic [3:0] idx, input logic [15:0] data);
    plan_row_t row;
    row.kind         = ROW_CFG;
    row.idx          = idx;
    row.data         = data;
    row.amount       = '0;
    row.typed        = 1'b0;
    row.want_min     = '0;
    row.want_unreach = 1'b0;
    plan = {plan, row};
  endfunction

  function automatic void plan_query(input logic [VAL_W-1:0] amt, input bit typed,
                                     input logic [VAL_W-1:0] want_min,
                                     input bit want_unreach);
    plan_row_t row;
    row.kind         = ROW_QUERY;
    row.idx          = '0;
    row.data         = '0;
    row.amount       = amt;
    row.typed        = typed;
    row.want_min     = want_min;
    row.want_unreach = want_unreach;
    plan = {plan, row};
  endfunction

  function automatic void build_plan();
    // no coins after reset: zero is free, everything else has no way
    plan_query(10'd0, 1, 10'd0, 0);
    plan_query(10'd1, 1, 10'd0, 1);
    plan_query(10'd1023, 1, 10'd0, 1);
    // unit coin: the count is the amount, up to the table end
    plan_cfg(REG_COIN_0, 16'd1);
    plan_query(10'd1023, 1, 10'd1023, 0);
    plan_query(10'd0, 1, 10'd0, 0);
    // largest coin next to the unit coin
    plan_cfg(REG_COIN_1, 16'd1023);
    plan_query(10'd1023, 1, 10'd1, 0);
    plan_query(10'd1022, 1, 10'd1022, 0);
    // spare indexes are dropped, so only the unit coin applies below 1023
    plan_cfg(REG_SPARE_8, 16'd2);
    plan_cfg(REG_SPARE_15, 16'd3);
    plan_query(10'd2, 1, 10'd2, 0);
    // junk above bit 9 is dropped (coin 4); greedy would pick 4+1+1 for 6
    plan_cfg(REG_COIN_0, 16'hFC04);
    plan_cfg(REG_COIN_1, 16'd0);
    plan_cfg(REG_COIN_2, 16'd3);
    plan_cfg(REG_COIN_3, 16'd1);
    plan_query(10'd6, 0, '0, 0);
    plan_query(10'd5, 0, '0, 0);
    // coins 4 and 3 only: some sums have no way, coins skipped when too big
    plan_cfg(REG_COIN_3, 16'd0);
    plan_query(10'd5, 0, '0, 0);
    plan_query(10'd1, 0, '0, 0);
    plan_query(10'd2, 0, '0, 0);
    plan_query(10'd7, 0, '0, 0);
    // upper slots at the largest value, one odd coin in slot 0
    plan_cfg(REG_COIN_4, 16'd1023);
    plan_cfg(REG_COIN_5, 16'd1023);
    plan_cfg(REG_COIN_6, 16'hFFFF);
    plan_cfg(REG_COIN_7, 16'd1023);
    plan_cfg(REG_COIN_0, 16'd7);
    plan_query(10'd513, 0, '0, 0);
    plan_query(10'd1000, 0, '0, 0);
    plan_query(10'd3, 0, '0, 0);
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int   i;
    int   ph;
    res_t typed_res;

    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    for (i = 0; i < REG_COUNT; i++)
      coin_val[i] = '0;
    set_idling(0);
    build_plan();

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed rows, no idling
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_block();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        typed_res.min_coins   = plan[i].want_min;
        typed_res.unreachable = plan[i].want_unreach;
        send_amount(plan[i].amount, plan[i].typed, typed_res);
      end
    end

    // random phases: a new coin set each, idling modes in turn
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle_block();
      set_idling(ph % 4);
      load_coins(ph);
      repeat (PHASE_ITEMS)
        send_amount(pick_amount(), 1'b0, typed_res);
    end

    // drain, then watch a while for stray results
    settle_block();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0 && answer_q.size() == 0)
      $display("[min_coin_change_top] OK");
    else
      $display("[min_coin_change_top] ERROR");
    $finish;
  end

endmodule
